// File: rtl/dscan_pkg.sv
// Shared types and constants for the DFA token scanner.
package dscan_pkg;

  localparam int SYMBOLS    = 4;
  localparam int SYM_W      = 2;
  localparam int FIELD_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IDX_W      = 2;
  localparam int PACKED_DFAS = CFG_DATA_W / FIELD_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DFA_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_STATES = 2'd2;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_D = 8'h64;

  typedef struct packed {
    logic               we;
    logic [FIELD_W-1:0] state;
    logic [SYM_W-1:0]   sym;
    logic [FIELD_W-1:0] next;
  } tbl_wr_t;

  typedef struct packed {
    logic               vld;
    logic [FIELD_W-1:0] state;
    logic [SYM_W-1:0]   sym;
    logic [FIELD_W-1:0] data;
  } byp_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [SYM_W-1:0] sym;
  } lane_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } res_t;

endpackage

// File: rtl/table_driven_dfa_token_scanner.sv
// Top level of the table-driven DFA token scanner.
// Each request is a table write, or one character stepped through all DFAs at once, each
// DFA reading its own copy of the transition table (one small RAM per symbol column,
// addressed by the next state so the row is ready when the character arrives). A scan
// request marked last yields one result in an output register backed by a one-entry skid
// buffer; in_stall rises only while that skid entry is occupied, so the sustained rate is one
// request per cycle whenever the output side keeps up. Table entries are cleared at reset
// through per-entry valid bits; no clearing pass is needed.
module table_driven_dfa_token_scanner #(
  parameter int NUM_DFAS    = 4,
  parameter int STATE_CODES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [dscan_pkg::FIELD_W-1:0]      in_table_state,
  input  logic [dscan_pkg::SYM_W-1:0]        in_table_symbol,
  input  logic [dscan_pkg::FIELD_W-1:0]      in_table_next,
  input  logic [7:0]                         in_char_code,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_token_found,
  output logic [dscan_pkg::IDX_W-1:0]        out_token_index,
  input  logic                               cfg_we,
  input  logic [dscan_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dscan_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dscan_pkg::*;

  localparam int SW     = $clog2(STATE_CODES);
  localparam int DEAD   = STATE_CODES - 1;
  localparam int VDEPTH = (2**SW) * SYMBOLS;

  logic [2:0]            dfa_count_r;
  logic [CFG_DATA_W-1:0] start_states_r, final_states_r, start_src;
  logic                  word_start_r, word_bad_r;
  logic [VDEPTH-1:0]     valid_r;
  byp_t                  byp_r;
  tbl_wr_t               tbl_wr;
  lane_ctl_t             ctl;
  res_t                  res, out_r, skid_r;
  logic                  out_valid_r, skid_vld_r;

  logic                  acc, scan_acc, char_bad, bad_eff, res_v, out_fire;
  logic                  start_wr;
  logic [NUM_DFAS-1:0]   lane_acc;

  assign acc      = in_valid && !in_stall;
  assign scan_acc = acc && (in_op == OP_SCAN);
  assign char_bad = (in_char_code < CHAR_A) || (in_char_code > CHAR_D);
  assign bad_eff  = (!word_start_r && word_bad_r) || char_bad;
  assign res_v    = scan_acc && in_last;
  assign start_wr = cfg_we && (cfg_index == CFG_START_STATES);
  assign start_src = start_wr ? cfg_wdata : start_states_r;

  always_comb begin
    tbl_wr.we    = acc && (in_op == OP_WRITE) && (32'(in_table_state) < 32'(DEAD));
    tbl_wr.state = in_table_state;
    tbl_wr.sym   = in_table_symbol;
    tbl_wr.next  = in_table_next;

    // restart on word end; follow a start-state rewrite only between words
    ctl.load = res_v || (start_wr && word_start_r);
    ctl.step = scan_acc && !char_bad;
    ctl.sym  = SYM_W'(in_char_code - CHAR_A);
  end

  for (genvar i = 0; i < NUM_DFAS; i++) begin : g_lane
    localparam bit PACKED = (i < PACKED_DFAS);
    localparam int FB     = PACKED ? FIELD_W * i : 0;

    dscan_lane #(
      .STATE_CODES(STATE_CODES)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .tbl_wr     (tbl_wr),
      .byp        (byp_r),
      .ctl        (ctl),
      .valid_bits (valid_r),
      .field_ok   (PACKED),
      .in_use     (32'(i) < 32'(dfa_count_r)),
      .start_field(start_src[FB +: FIELD_W]),
      .final_field(final_states_r[FB +: FIELD_W]),
      .accept     (lane_acc[i])
    );
  end

  always_comb begin
    res.found = 1'b0;
    res.index = '0;
    // lowest accepting index wins
    for (int i = NUM_DFAS - 1; i >= 0; i--) begin
      if (lane_acc[i]) begin
        res.found = 1'b1;
        res.index = IDX_W'(i);
      end
    end
    if (bad_eff) begin
      res.found = 1'b0;
      res.index = '0;
    end
  end

  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfa_count_r    <= 3'd1;
      start_states_r <= '0;
      final_states_r <= '0;
      word_start_r   <= 1'b1;
      word_bad_r     <= 1'b0;
      valid_r        <= '0;
      byp_r.vld      <= 1'b0;
      out_valid_r    <= 1'b0;
      skid_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DFA_COUNT:    dfa_count_r    <= cfg_wdata[2:0];
          CFG_START_STATES: start_states_r <= cfg_wdata;
          CFG_FINAL_STATES: final_states_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (scan_acc) begin
        word_start_r <= in_last;
        word_bad_r   <= in_last ? 1'b0 : bad_eff;
      end

      if (tbl_wr.we) begin
        valid_r[{SW'(in_table_state), in_table_symbol}] <= 1'b1;
      end
      byp_r.vld   <= tbl_wr.we;
      byp_r.state <= in_table_state;
      byp_r.sym   <= in_table_symbol;
      byp_r.data  <= in_table_next;

      if (!out_valid_r || out_fire) begin
        if (skid_vld_r) begin
          out_valid_r <= 1'b1;
          skid_vld_r  <= res_v;
        end else begin
          out_valid_r <= res_v;
        end
      end else if (res_v) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_vld_r) begin
        out_r  <= skid_r;
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign in_stall        = skid_vld_r;
  assign out_valid       = out_valid_r;
  assign out_token_found = out_r.found;
  assign out_token_index = out_r.index;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_valid_r)
    else $error("skid entry held without a pending output");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == OP_SCAN) && in_last) |=> out_valid)
    else $error("last character produced no result");

  a_word_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == OP_SCAN) && in_last) |=> (word_start_r && !word_bad_r))
    else $error("word state not restarted after last character");

  a_error_clean_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_token_found) |-> (out_token_index == '0))
    else $error("lexical error reported with nonzero index");

endmodule

// File: rtl/dscan_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dscan_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dscan_lane.sv
// One DFA lane: private copy of the transition table and its state register.
module dscan_lane #(
  parameter int STATE_CODES = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  dscan_pkg::tbl_wr_t                           tbl_wr,
  input  dscan_pkg::byp_t                              byp,
  input  dscan_pkg::lane_ctl_t                         ctl,
  input  logic [(2**$clog2(STATE_CODES))*dscan_pkg::SYMBOLS-1:0] valid_bits,
  input  logic                                         field_ok,
  input  logic                                         in_use,
  input  logic [dscan_pkg::FIELD_W-1:0]                start_field,
  input  logic [dscan_pkg::FIELD_W-1:0]                final_field,
  output logic                                         accept
);
  import dscan_pkg::*;

  localparam int SW   = $clog2(STATE_CODES);
  localparam int DEAD = STATE_CODES - 1;

  logic [SW-1:0]      eff_r, eff_nxt;
  logic [SW-1:0]      lookup, stepped, start_st;
  logic [FIELD_W-1:0] q [SYMBOLS];
  logic [FIELD_W-1:0] raw;
  logic               hit;

  for (genvar g = 0; g < SYMBOLS; g++) begin : g_col
    dscan_ram #(
      .WIDTH(FIELD_W),
      .DEPTH(STATE_CODES)
    ) u_ram (
      .clk  (clk),
      .we   (tbl_wr.we && (tbl_wr.sym == SYM_W'(g))),
      .waddr(SW'(tbl_wr.state)),
      .wdata(tbl_wr.next),
      .raddr(eff_nxt),
      .rdata(q[g])
    );
  end

  always_comb begin
    // the RAM read lags one write; take a same-edge write from the bypass
    if (byp.vld && (32'(byp.state) == 32'(eff_r)) && (byp.sym == ctl.sym)) begin
      raw = byp.data;
    end else begin
      raw = q[ctl.sym];
    end
    hit = valid_bits[{eff_r, ctl.sym}];

    if ((32'(eff_r) >= 32'(DEAD)) || !hit || (32'(raw) >= 32'(DEAD))) begin
      lookup = SW'(DEAD);
    end else begin
      lookup = SW'(raw);
    end
    stepped = ctl.step ? lookup : eff_r;

    if (!field_ok || (32'(start_field) >= 32'(DEAD))) begin
      start_st = SW'(DEAD);
    end else begin
      start_st = SW'(start_field);
    end
    eff_nxt = ctl.load ? start_st : stepped;

    accept = in_use && field_ok && (32'(stepped) != 32'(DEAD)) &&
             (32'(stepped) == 32'(final_field));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r <= '0;
    end else begin
      eff_r <= eff_nxt;
    end
  end

endmodule

// File: tb/table_driven_dfa_token_scanner_tb.sv
// Self-checking testbench for the table-driven DFA token scanner.
module table_driven_dfa_token_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dscan_pkg::*;

  localparam logic [FIELD_W-1:0] DEAD_CODE = 4'd15;
  localparam int NUM_LANES     = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 150;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] tstate;
    logic [SYM_W-1:0]   tsym;
    logic [FIELD_W-1:0] tnext;
    logic [7:0]         ch;
    logic               last;
  } scan_req_t;

  typedef struct packed {
    scan_req_t req;
    logic      typed;
    res_t      want;
  } plan_row_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_op;
  logic [FIELD_W-1:0]   in_table_state;
  logic [SYM_W-1:0]     in_table_symbol;
  logic [FIELD_W-1:0]   in_table_next;
  logic [7:0]           in_char_code;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_token_found;
  logic [IDX_W-1:0]     out_token_index;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  table_driven_dfa_token_scanner u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_table_state  (in_table_state),
    .in_table_symbol (in_table_symbol),
    .in_table_next   (in_table_next),
    .in_char_code    (in_char_code),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_found (out_token_found),
    .out_token_index (out_token_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Scanner shadow state
  logic [FIELD_W-1:0] trans_tbl [SYMBOLS*16];
  logic [FIELD_W-1:0] lane_state [NUM_LANES];
  bit                 fresh_word;
  bit                 word_broken;
  logic [2:0]         dfa_count;
  logic [15:0]        start_codes;
  logic [15:0]        final_codes;

  res_t token_q [$];
  int   mismatches;
  int   burst_left;
  bit   valid_hi;

  // Apply one accepted request to the shadow state; returns 1 when a token verdict is due.
  function automatic bit dfa_step(input scan_req_t r, output res_t verdict);
    int               lanes;
    logic [FIELD_W-1:0] s;
    logic [SYM_W-1:0]   sym;
    verdict = '0;
    if (r.op == OP_WRITE) begin
      if (r.tstate != DEAD_CODE) trans_tbl[{r.tstate, r.tsym}] = r.tnext;
      return 1'b0;
    end
    if (fresh_word) begin
      for (int i = 0; i < NUM_LANES; i++) lane_state[i] = start_codes[4*i +: 4];
      word_broken = 1'b0;
    end
    fresh_word = 1'b0;
    if (r.ch < CHAR_A || r.ch > CHAR_D) begin
      word_broken = 1'b1;
    end else begin
      sym = SYM_W'(r.ch - CHAR_A);
      for (int i = 0; i < NUM_LANES; i++) begin
        s = lane_state[i];
        if (s != DEAD_CODE) s = trans_tbl[{s, sym}];
        lane_state[i] = s;
      end
    end
    if (!r.last) return 1'b0;
    lanes = (dfa_count > NUM_LANES) ? NUM_LANES : int'(dfa_count);
    if (!word_broken) begin
      for (int i = 0; i < lanes; i++) begin
        if (!verdict.found && lane_state[i] != DEAD_CODE &&
            lane_state[i] == final_codes[4*i +: 4]) begin
          verdict.found = 1'b1;
          verdict.index = IDX_W'(i);
        end
      end
    end
    fresh_word  = 1'b1;
    word_broken = 1'b0;
    return 1'b1;
  endfunction

  function automatic plan_row_t tbl_row(input int s, input int y, input int nx);
    plan_row_t row;
    row = '0;
    row.req.op     = OP_WRITE;
    row.req.tstate = FIELD_W'(s);
    row.req.tsym   = SYM_W'(y);
    row.req.tnext  = FIELD_W'(nx);
    return row;
  endfunction

  function automatic plan_row_t chr_row(input logic [7:0] c, input logic lst);
    plan_row_t row;
    row = '0;
    row.req.op   = OP_SCAN;
    row.req.ch   = c;
    row.req.last = lst;
    return row;
  endfunction

  // Closing character of a word that must end with no token found
  function automatic plan_row_t miss_row(input logic [7:0] c);
    plan_row_t row;
    row = chr_row(c, 1'b1);
    row.typed = 1'b1;
    row.want  = '0;
    return row;
  endfunction

  function automatic logic [15:0] pick_codes(input int span);
    logic [15:0] v;
    for (int i = 0; i < NUM_LANES; i++)
      v[4*i +: 4] = ($urandom_range(0, 7) == 0) ? DEAD_CODE : FIELD_W'($urandom_range(0, span));
    return v;
  endfunction

  task automatic hold_sender();
    if (valid_hi) begin
      in_valid <= 1'b0;
      valid_hi = 1'b0;
    end
  endtask

  task automatic issue(input scan_req_t r, input logic typed, input res_t typed_res);
    res_t verdict;
    bit   due;
    if (burst_left <= 0) begin
      hold_sender();
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid        <= 1'b1;
    valid_hi        = 1'b1;
    in_op           <= r.op;
    in_table_state  <= r.tstate;
    in_table_symbol <= r.tsym;
    in_table_next   <= r.tnext;
    in_char_code    <= r.ch;
    in_last         <= r.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    due = dfa_step(r, verdict);
    if (due) token_q.insert(token_q.size(), typed ? typed_res : verdict);
  endtask

  task automatic issue_checked(input scan_req_t r);
    issue(r, 1'b0, '0);
  endtask

  // Wait for every pending verdict plus the pipeline tail before touching registers.
  task automatic drain();
    hold_sender();
    while (token_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DFA_COUNT:    dfa_count   = val[2:0];
      CFG_START_STATES: start_codes = val;
      CFG_FINAL_STATES: final_codes = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic scan_req_t rand_write(input int span);
    scan_req_t r;
    r        = scan_req_t'($urandom);
    r.op     = OP_WRITE;
    r.tstate = FIELD_W'($urandom_range(0, span));
    r.tsym   = SYM_W'($urandom_range(0, 3));
    r.tnext  = FIELD_W'($urandom_range(0, 15));
    return r;
  endfunction

  task automatic run_phase(input int p);
    int          span;
    int          sent;
    int          len;
    int          bad_pos;
    bit          corrupt;
    logic [2:0]  count;
    logic [15:0] starts;
    logic [15:0] finals;
    scan_req_t   r;
    case ($urandom_range(0, 3))
      0: span = 1;
      1: span = 3;
      2: span = 7;
      default: span = 14;
    endcase
    starts = pick_codes(span);
    finals = pick_codes(span);
    case (p)
      0: count = 3'd0;
      1: count = 3'd7;
      2: begin
        count  = 3'd4;
        starts = 16'hFFFF;
        finals = 16'hFFFF;
      end
      3: begin
        count  = 3'd4;
        starts = 16'h0000;
      end
      4: count = 3'd1;
      default: count = 3'($urandom_range(0, 7));
    endcase
    drain();
    write_reg(CFG_DFA_COUNT, {13'($urandom), count});
    write_reg(CFG_START_STATES, starts);
    write_reg(CFG_FINAL_STATES, finals);

    sent = 0;
    for (int s = 0; s <= span; s++) begin
      for (int y = 0; y < SYMBOLS; y++) begin
        r       = rand_write(span);
        r.tstate = FIELD_W'(s);
        r.tsym   = SYM_W'(y);
        r.tnext  = ($urandom_range(0, 11) == 0) ? DEAD_CODE : FIELD_W'($urandom_range(0, span));
        issue_checked(r);
        sent++;
      end
    end

    while (sent < PHASE_ITEMS) begin
      // stray write between words, dead row included
      if ($urandom_range(0, 11) == 0) begin
        issue_checked(rand_write(15));
        sent++;
      end
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
      corrupt = ($urandom_range(0, 4) == 0);
      bad_pos = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 24) == 0) begin
          issue_checked(rand_write(span));
          sent++;
        end
        r      = scan_req_t'($urandom);
        r.op   = OP_SCAN;
        r.ch   = (corrupt && k == bad_pos) ? 8'($urandom_range(0, 255))
                                            : CHAR_A + 8'($urandom_range(0, 3));
        r.last = (k == len - 1);
        issue_checked(r);
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure: four patterns (open, random, periodic, heavy), switched at random
  initial begin
    rx_mode_t mode;
    int       left;
    int       tick;
    out_stall = 1'b0;
    mode      = RX_OPEN;
    left      = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(50, 300);
      end
      left--;
      tick++;
      case (mode)
        RX_OPEN:     out_stall <= 1'b0;
        RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        RX_PERIODIC: out_stall <= ((tick % 16) < 11);
        default:     out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $display("%0t: result with none pending: expected nothing, got found=%0b index=%0d",
                 $time, out_token_found, out_token_index);
        mismatches++;
      end else begin
        want = token_q.pop_front();
        if (out_token_found !== want.found) begin
          $display("%0t: token_found expected %0b got %0b", $time, want.found, out_token_found);
          mismatches++;
        end
        if (out_token_index !== want.index) begin
          $display("%0t: token_index expected %0d got %0d", $time, want.index, out_token_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    plan_row_t plan [24];
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_WRITE;
    in_table_state  = '0;
    in_table_symbol = '0;
    in_table_next   = '0;
    in_char_code    = '0;
    in_last         = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_DFA_COUNT;
    cfg_wdata       = '0;
    mismatches      = 0;
    burst_left      = 0;
    valid_hi        = 1'b0;
    for (int i = 0; i < SYMBOLS*16; i++) trans_tbl[i] = DEAD_CODE;
    for (int i = 0; i < NUM_LANES; i++) lane_state[i] = '0;
    fresh_word  = 1'b1;
    word_broken = 1'b0;
    dfa_count   = 3'd1;
    start_codes = '0;
    final_codes = '0;

    // Reset registers: one DFA, start 0, accept 0, empty table
    plan = '{
      miss_row(CHAR_A),            // empty table sends every DFA dead
      miss_row(8'h00),
      miss_row(8'hFF),
      miss_row(CHAR_A - 8'd1),
      miss_row(CHAR_D + 8'd1),
      tbl_row(0, 0, 1),
      tbl_row(1, 1, 0),
      tbl_row(0, 3, 0),
      chr_row(CHAR_A, 1'b0),
      chr_row(CHAR_A + 8'd1, 1'b1),
      chr_row(CHAR_D, 1'b0),
      chr_row(CHAR_A, 1'b1),
      chr_row(CHAR_A, 1'b0),
      chr_row(8'h7A, 1'b0),
      miss_row(CHAR_A + 8'd1),     // bad character earlier in the word
      tbl_row(15, 0, 0),           // dead row stays without transitions
      tbl_row(0, 2, 15),
      chr_row(CHAR_A + 8'd2, 1'b0),
      miss_row(CHAR_A),            // once dead, always dead
      chr_row(CHAR_A, 1'b0),
      tbl_row(1, 0, 0),            // write lands mid-word
      chr_row(CHAR_A, 1'b1),
      tbl_row(14, 3, 15),
      chr_row(CHAR_D, 1'b1)
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) issue(plan[i].req, plan[i].typed, plan[i].want);

    for (int p = 0; p < PHASES; p++) run_phase(p);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
